### sv/assert_macros.svh
// Assertion helpers used by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/mhbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhbw_pkg;

    // Write modes carried with each output word
    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_OR    = 2'd1;
    localparam logic [1:0] MODE_AND   = 2'd2;

    localparam logic [5:0] COLUMNS_RESET = 6'd40;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // capture the input word
        logic setup;    // compute address, byte range and edge pixels
        logic advance;  // step to the next byte
    } mhbw_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic skip;     // request draws nothing
        logic at_last;  // current byte is the last of the span
    } mhbw_status_t;

    function automatic logic [7:0] fill_pattern(input logic [1:0] color);
        logic [7:0] pat;
        unique case (color)
            2'd0:    pat = 8'h00;
            2'd1:    pat = 8'h55;
            2'd2:    pat = 8'haa;
            default: pat = 8'hff;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### sv/mhbw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mhbw_ctrl
    import mhbw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire mhbw_status_t status,
    output mhbw_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.skip ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/mhbw_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module mhbw_dpath
    import mhbw_pkg::*;
#(
    parameter int MAX_COLUMNS = 40,
    parameter int CHAR_ROWS   = 25
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mhbw_cmd_t    cmd,
    output mhbw_status_t      status,
    input  wire logic         cfg_we,
    input  wire logic [5:0]   cfg_columns,
    input  wire logic [7:0]   start_x,
    input  wire logic [7:0]   row_y,
    input  wire logic [7:0]   span_length,
    input  wire logic [1:0]   pixel_color,
    output logic      [12:0]  write_offset,
    output logic      [7:0]   write_data,
    output logic      [1:0]   write_mode,
    output logic              last_write
);

    localparam int CLOG_COLS = $clog2(MAX_COLUMNS + 1);
    localparam int COLS_W    = (CLOG_COLS > 6) ? CLOG_COLS : 6;
    localparam int WIDE_W    = COLS_W + 2;
    localparam int SPAN_W    = (WIDE_W > 9) ? WIDE_W : 9;
    localparam int BYTE_W    = SPAN_W - 2;
    localparam int PROD_W    = COLS_W + 8;
    localparam int ROW_LIMIT = CHAR_ROWS * 8;
    localparam logic [COLS_W-1:0] MAX_COLS = COLS_W'(MAX_COLUMNS);
    localparam logic [8:0]        ROW_LIM  = 9'(ROW_LIMIT);

    logic [5:0]        columns_reg;
    logic [7:0]        x_reg;
    logic [7:0]        y_reg;
    logic [7:0]        len_reg;
    logic [1:0]        color_reg;
    logic [12:0]       cursor_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] last_reg;
    logic [1:0]        hi_reg;
    logic              first_reg;

    // Setup arithmetic
    logic [COLS_W-1:0] cols;
    logic [SPAN_W-1:0] width;
    logic [SPAN_W-1:0] end_sum;
    logic [SPAN_W-1:0] end_clip;
    logic [SPAN_W-1:0] end_m1;
    logic [PROD_W-1:0] row_base;
    logic [12:0]       first_off;
    logic              skip;

    // Per-byte write generation
    logic [1:0] lo;
    logic [1:0] hi;
    logic [7:0] mask;
    logic [7:0] pat;

    always_comb
    begin
        cols     = (COLS_W'(columns_reg) > MAX_COLS)
                   ? MAX_COLS : COLS_W'(columns_reg);
        width    = SPAN_W'({cols, 2'b00});
        end_sum  = SPAN_W'(x_reg) + SPAN_W'(len_reg);
        end_clip = (end_sum > width) ? width : end_sum;
        end_m1   = end_clip - SPAN_W'(1);
        skip     = (len_reg == 8'd0) || (SPAN_W'(x_reg) >= width)
                   || ({1'b0, y_reg} >= ROW_LIM);
        row_base = PROD_W'(cols) * PROD_W'({y_reg[7:3], 3'b000});
        first_off = row_base[12:0] + 13'({5'd0, y_reg[2:0]})
                    + 13'({x_reg[7:2], 3'b000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
        end
        else if (cfg_we)
        begin
            columns_reg <= cfg_columns;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= start_x;
            y_reg     <= row_y;
            len_reg   <= span_length;
            color_reg <= pixel_color;
        end
        if (cmd.setup)
        begin
            cursor_reg <= first_off;
            byte_reg   <= BYTE_W'(x_reg[7:2]);
            last_reg   <= end_m1[SPAN_W-1:2];
            hi_reg     <= end_m1[1:0];
            first_reg  <= 1'b1;
        end
        else if (cmd.advance)
        begin
            cursor_reg <= cursor_reg + 13'd8;
            byte_reg   <= byte_reg + BYTE_W'(1);
            first_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        status.skip    = skip;
        status.at_last = (byte_reg == last_reg);
        lo   = first_reg ? x_reg[1:0] : 2'd0;
        hi   = status.at_last ? hi_reg : 2'd3;
        // pixel 0 sits in bits 7..6
        mask = (8'hff >> {lo, 1'b0}) & (8'hff << {2'd3 - hi, 1'b0});
        pat  = fill_pattern(color_reg);
        if ((lo == 2'd0) && (hi == 2'd3))
        begin
            write_data = pat;
            write_mode = MODE_STORE;
        end
        else if (color_reg == 2'd0)
        begin
            write_data = ~mask;
            write_mode = MODE_AND;
        end
        else
        begin
            write_data = pat & mask;
            write_mode = MODE_OR;
        end
        write_offset = cursor_reg;
        last_write   = status.at_last;
    end

endmodule

`default_nettype wire

### sv/multicolor_hline_byte_writer_unit.sv
// Flow: an accepted word is followed by the setup state; the first write word
//   is offered on the next cycle, then one write word per cycle while m_axis_tready is high.
// A new request is taken only after the last write word (at most MAX_COLUMNS per
//   request) is handed over, or after setup when the request draws nothing.
// Reset (rst_n low, asynchronous): controller returns to idle, screen_columns
//   returns to 40, no word is pending on either side.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multicolor_hline_byte_writer_unit
    import mhbw_pkg::*;
#(
    parameter int MAX_COLUMNS = 40,   // widest row in character cells, 1..80
    parameter int CHAR_ROWS   = 25    // character rows on screen, 1..32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: screen_columns
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // start_x[7:0], row_y[15:8],
                                             // span_length[23:16], pixel_color[25:24]
    // byte write stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // write_offset[12:0], write_data[20:13],
                                             // write_mode[22:21]
    output logic             m_axis_tlast    // last_write
);

    mhbw_cmd_t    cmd;
    mhbw_status_t status;

    logic [12:0] write_offset;
    logic [7:0]  write_data;
    logic [1:0]  write_mode;

    // The user must write the register only while idle; the block does not enforce it, so always take it.
    assign cfg_ready = 1'b1;

    // Sequencer: idle -> setup -> emit words -> idle, or setup -> idle when the request draws nothing
    mhbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Address, byte range and mask generation
    mhbw_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CHAR_ROWS   (CHAR_ROWS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_columns  (cfg_data),
        .start_x      (s_axis_tdata[7:0]),
        .row_y        (s_axis_tdata[15:8]),
        .span_length  (s_axis_tdata[23:16]),
        .pixel_color  (s_axis_tdata[25:24]),
        .write_offset (write_offset),
        .write_data   (write_data),
        .write_mode   (write_mode),
        .last_write   (m_axis_tlast)
    );

    // Pack the outgoing word, zero fill to a whole byte
    assign m_axis_tdata = {1'b0, write_mode, write_data, write_offset};

    // One request at a time: never take a request while a write is offered.
    `ASSERT_SAME(a_one_at_a_time, m_axis_tvalid, !s_axis_tready)
    // An accepted request always goes through setup before any write is offered.
    `ASSERT_NEXT(a_setup_gap, s_axis_tvalid && s_axis_tready, !m_axis_tvalid && !s_axis_tready)
    // Handing over the final word frees the input side for the next request.
    `ASSERT_NEXT(a_last_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    // Write mode is never the unused code.
    `ASSERT_SAME(a_mode_legal, m_axis_tvalid, m_axis_tdata[22:21] != 2'd3)

endmodule

`default_nettype wire
